// File: rtl/oep_pkg.sv
// ----------------------------------------------------------------------------
// oep_pkg
// Shared types, constants and constant tables of the orbit eye position unit.
// ----------------------------------------------------------------------------
`default_nettype none

package oep_pkg;

  // Angle units: 1/64 degree
  localparam int YAW_FULL    = 23040;
  localparam int YAW_HALF    = 11520;
  localparam int YAW_QUART   = 5760;
  localparam int PITCH_LIMIT = 5393;

  // Radius clamp, Q.8
  localparam logic [14:0] RADIUS_MIN   = 15'd256;
  localparam logic [14:0] RADIUS_MAX   = 15'd25600;
  localparam logic [14:0] RADIUS_RESET = 15'd2560;

  // Output saturation bounds
  localparam int EYE_MIN = -8414208;
  localparam int EYE_MAX = 8414207;

  // CORDIC datapath
  localparam int ZW = 34;   // angle accumulator, Q30
  localparam int XW = 34;   // x/y accumulators, Q30
  localparam int AW = 14;   // reduced angle in 1/64 degree, signed
  localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam longint PI_Q30 = 64'd3373259426;

  // Register indexes
  localparam logic [2:0] REG_RADIUS   = 3'd0;
  localparam logic [2:0] REG_TARGET_X = 3'd1;
  localparam logic [2:0] REG_TARGET_Y = 3'd2;
  localparam logic [2:0] REG_TARGET_Z = 3'd3;

  // Request passed from the front end to the back end
  typedef struct packed {
    logic signed [ZW-1:0] z_yaw;
    logic signed [ZW-1:0] z_pitch;
    logic                 flip;
  } oep_angle_t;

  // Degree-to-radian scaling split into two table lookups:
  // |a| = hi*64 + lo, quotient and remainder of k*step*pi/YAW_HALF.
  typedef logic [31:0] quot_arr_t [128];
  typedef logic [13:0] rem_arr_t  [128];

  function automatic quot_arr_t build_quot(input longint step);
    quot_arr_t q;
    longint    n;
    for (int i = 0; i < 128; i++) begin
      n    = longint'(i) * step * PI_Q30;
      q[i] = 32'(n / YAW_HALF);
    end
    return q;
  endfunction

  function automatic rem_arr_t build_rem(input longint step);
    rem_arr_t r;
    longint   n;
    for (int i = 0; i < 128; i++) begin
      n    = longint'(i) * step * PI_Q30;
      r[i] = 14'(n % YAW_HALF);
    end
    return r;
  endfunction

  localparam quot_arr_t HI_QUOT = build_quot(64);
  localparam rem_arr_t  HI_REM  = build_rem(64);
  localparam quot_arr_t LO_QUOT = build_quot(1);
  localparam rem_arr_t  LO_REM  = build_rem(1);

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = 34'sd843314856;
      1:       v = 34'sd497837829;
      2:       v = 34'sd263043836;
      3:       v = 34'sd133525158;
      4:       v = 34'sd67021686;
      5:       v = 34'sd33543515;
      6:       v = 34'sd16775850;
      7:       v = 34'sd8388437;
      8:       v = 34'sd4194282;
      9:       v = 34'sd2097149;
      10:      v = 34'sd1048575;
      11:      v = 34'sd524287;
      12:      v = 34'sd262143;
      13:      v = 34'sd131071;
      14:      v = 34'sd65535;
      15:      v = 34'sd32767;
      16:      v = 34'sd16383;
      17:      v = 34'sd8191;
      18:      v = 34'sd4095;
      19:      v = 34'sd2047;
      20:      v = 34'sd1023;
      21:      v = 34'sd511;
      22:      v = 34'sd255;
      23:      v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/oep_if.sv
// ----------------------------------------------------------------------------
// oep interfaces
// Valid/ready channels for pose requests, eye results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface oep_pose_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw_angle;
  logic signed [15:0] pitch_angle;
  modport source (output valid, yaw_angle, pitch_angle, input ready);
  modport sink   (input valid, yaw_angle, pitch_angle, output ready);
endinterface

interface oep_eye_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] eye_x;
  logic signed [24:0] eye_y;
  logic signed [24:0] eye_z;
  modport source (output valid, eye_x, eye_y, eye_z, input ready);
  modport sink   (input valid, eye_x, eye_y, eye_z, output ready);
endinterface

interface oep_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [23:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// File: rtl/orbit_eye_position_unit.sv
// ----------------------------------------------------------------------------
// orbit_eye_position_unit
// Orbit camera eye position from yaw and pitch.
// ----------------------------------------------------------------------------
// One pose request is taken every cycle while the output is not stalled; each
// gives one eye position after three angle-reduction stages, one queue slot,
// the CORDIC stages, Q15 rounding, two multiply stages and the output
// register. The throughput is set by the fully pipelined CORDIC and multiply
// path, which accepts one request per cycle unless the output stalls.
// Registers (radius, target) are to be written only while the unit is idle;
// the unit itself does not enforce this. The radius is clamped to 1.0..100.0.
`default_nettype none

module orbit_eye_position_unit
  import oep_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  oep_pose_if.sink   pose_i,
  oep_eye_if.source  eye_o,
  oep_cfg_if.sink    cfg_i
);

  logic [14:0]        radius_q;
  logic signed [23:0] tx_q, ty_q, tz_q;
  logic [14:0]        radius_wr;

  logic       fq_push_valid, fq_push_ready, fq_pop_valid, fq_pop_ready;
  oep_angle_t fq_push_data, fq_pop_data;

  // Register file
  assign cfg_i.ready = 1'b1;
  always_comb begin
    radius_wr = cfg_i.wdata[14:0];
    if (radius_wr < RADIUS_MIN) radius_wr = RADIUS_MIN;
    if (radius_wr > RADIUS_MAX) radius_wr = RADIUS_MAX;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
      tx_q     <= '0;
      ty_q     <= '0;
      tz_q     <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        REG_RADIUS:   radius_q <= radius_wr;
        REG_TARGET_X: tx_q     <= cfg_i.wdata;
        REG_TARGET_Y: ty_q     <= cfg_i.wdata;
        REG_TARGET_Z: tz_q     <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  oep_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pose_i.valid),
    .in_ready_o  (pose_i.ready),
    .yaw_i       (pose_i.yaw_angle),
    .pitch_i     (pose_i.pitch_angle),
    .out_valid_o (fq_push_valid),
    .out_ready_i (fq_push_ready),
    .out_o       (fq_push_data)
  );

  oep_fifo #(.DEPTH(4)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_push_valid),
    .push_ready_o (fq_push_ready),
    .push_data_i  (fq_push_data),
    .pop_valid_o  (fq_pop_valid),
    .pop_ready_i  (fq_pop_ready),
    .pop_data_o   (fq_pop_data)
  );

  oep_back #(.STAGES(CORDIC_STAGES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fq_pop_valid),
    .in_ready_o  (fq_pop_ready),
    .in_i        (fq_pop_data),
    .radius_i    (radius_q),
    .target_x_i  (tx_q),
    .target_y_i  (ty_q),
    .target_z_i  (tz_q),
    .out_valid_o (eye_o.valid),
    .out_ready_i (eye_o.ready),
    .eye_x_o     (eye_o.eye_x),
    .eye_y_o     (eye_o.eye_y),
    .eye_z_o     (eye_o.eye_z)
  );

endmodule

`default_nettype wire

// File: rtl/oep_front.sv
// ----------------------------------------------------------------------------
// oep_front
// Angle reduction: yaw wrap and half-turn fold, pitch clamp, conversion of
// both angles to Q30 radians. Three stages with a common stall.
// ----------------------------------------------------------------------------
`default_nettype none

module oep_front
  import oep_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] yaw_i,
  input  wire logic signed [15:0] pitch_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output oep_angle_t              out_o
);

  logic en;
  logic v1_q, v2_q, v3_q;

  // Stage 1: wrap and clamp
  logic signed [16:0] w0, w1, w2, w3, w4;
  logic               flip;
  logic signed [15:0] pc;
  logic signed [AW-1:0] ay_q, ap_q;
  logic                 flip1_q;

  // Stage 2: table lookups
  logic [AW-2:0] magy, magp;
  logic [32:0]   sumy, sump;
  logic [14:0]   remy, remp;
  logic [32:0]   sumy_q, sump_q;
  logic          cy_q, cp_q, ny_q, np_q, flip2_q;

  // Stage 3: apply carry and sign
  logic [32:0] zy_mag, zp_mag;
  oep_angle_t  out_q;

  assign en         = !v3_q || out_ready_i;
  assign in_ready_o = en;

  // Yaw reduction to [-90, 90] degrees with fold flag
  always_comb begin
    w0 = 17'(yaw_i);
    w1 = w0[16] ? w0 + 17'sd23040 : w0;
    w2 = w1[16] ? w1 + 17'sd23040 : w1;
    w2 = (w2 >= 17'sd23040) ? w2 - 17'sd23040 : w2;
    w3 = (w2 >= 17'(YAW_HALF)) ? w2 - 17'sd23040 : w2;
    flip = 1'b0;
    w4   = w3;
    if (w3 > 17'(YAW_QUART)) begin
      w4   = w3 - 17'(YAW_HALF);
      flip = 1'b1;
    end else if (w3 < -17'(YAW_QUART)) begin
      w4   = w3 + 17'(YAW_HALF);
      flip = 1'b1;
    end
    pc = pitch_i;
    if (pitch_i > 16'(PITCH_LIMIT)) pc = 16'(PITCH_LIMIT);
    if (pitch_i < -16'(PITCH_LIMIT)) pc = -16'(PITCH_LIMIT);
  end

  // Scaled magnitude as hi/lo table sums
  always_comb begin
    magy = ay_q[AW-1] ? (AW-1)'(-ay_q) : ay_q[AW-2:0];
    magp = ap_q[AW-1] ? (AW-1)'(-ap_q) : ap_q[AW-2:0];
    sumy = 33'(HI_QUOT[magy[12:6]]) + 33'(LO_QUOT[{1'b0, magy[5:0]}]);
    sump = 33'(HI_QUOT[magp[12:6]]) + 33'(LO_QUOT[{1'b0, magp[5:0]}]);
    remy = 15'(HI_REM[magy[12:6]]) + 15'(LO_REM[{1'b0, magy[5:0]}]);
    remp = 15'(HI_REM[magp[12:6]]) + 15'(LO_REM[{1'b0, magp[5:0]}]);
    zy_mag = sumy_q + 33'(cy_q);
    zp_mag = sump_q + 33'(cp_q);
  end

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      ay_q    <= AW'(w4);
      ap_q    <= AW'(pc);
      flip1_q <= flip;
      sumy_q  <= sumy;
      sump_q  <= sump;
      cy_q    <= (remy >= 15'(YAW_HALF));
      cp_q    <= (remp >= 15'(YAW_HALF));
      ny_q    <= ay_q[AW-1];
      np_q    <= ap_q[AW-1];
      flip2_q <= flip1_q;
      out_q.z_yaw   <= ny_q ? -$signed({1'b0, zy_mag}) : $signed({1'b0, zy_mag});
      out_q.z_pitch <= np_q ? -$signed({1'b0, zp_mag}) : $signed({1'b0, zp_mag});
      out_q.flip    <= flip2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// File: rtl/oep_fifo.sv
// ----------------------------------------------------------------------------
// oep_fifo
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module oep_fifo
  import oep_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_valid_i,
  output logic             push_ready_o,
  input  wire oep_angle_t  push_data_i,
  output logic             pop_valid_o,
  input  wire logic        pop_ready_i,
  output oep_angle_t       pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  oep_angle_t    mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH)) else $error("queue overfilled");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("push without pop lost a request");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == CW'(DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("pointers disagree with fill count");

endmodule

`default_nettype wire

// File: rtl/oep_cordic.sv
// ----------------------------------------------------------------------------
// oep_cordic
// Unrolled rotation-mode CORDIC, one registered stage per iteration.
// ----------------------------------------------------------------------------
`default_nettype none

module oep_cordic
  import oep_pkg::*;
#(
  parameter int STAGES = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [ZW-1:0] z_i,
  output logic signed [XW-1:0]      sin_o,
  output logic signed [XW-1:0]      cos_o
);

  logic signed [XW-1:0] x_q [STAGES];
  logic signed [XW-1:0] y_q [STAGES];
  logic signed [ZW-1:0] z_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [XW-1:0] xi, yi;
    logic signed [ZW-1:0] zi;
    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN_Q30;
      assign yi = '0;
      assign zi = z_i;
    end else begin : g_next
      assign xi = x_q[i-1];
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
    end
    // Rotate toward zero residual angle
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!zi[ZW-1]) begin
          x_q[i] <= xi - (yi >>> i);
          y_q[i] <= yi + (xi >>> i);
          z_q[i] <= zi - atan_q30(i);
        end else begin
          x_q[i] <= xi + (yi >>> i);
          y_q[i] <= yi - (xi >>> i);
          z_q[i] <= zi + atan_q30(i);
        end
      end
    end
  end

  assign sin_o = y_q[STAGES-1];
  assign cos_o = x_q[STAGES-1];

endmodule

`default_nettype wire

// File: rtl/oep_back.sv
// ----------------------------------------------------------------------------
// oep_back
// Sine/cosine of yaw and pitch, Q15 rounding, radius products, target add
// and saturation into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module oep_back
  import oep_pkg::*;
#(
  parameter int STAGES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire oep_angle_t         in_i,
  input  wire logic [14:0]        radius_i,
  input  wire logic signed [23:0] target_x_i,
  input  wire logic signed [23:0] target_y_i,
  input  wire logic signed [23:0] target_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [24:0]      eye_x_o,
  output logic signed [24:0]      eye_y_o,
  output logic signed [24:0]      eye_z_o
);

  logic en;
  logic v_q [STAGES];
  logic f_q [STAGES];
  logic vr_q, vm1_q, vm2_q, vo_q;

  logic signed [XW-1:0] sy_raw, cy_raw, sp_raw, cp_raw;
  logic signed [15:0]   sy_q, cy_q, sp_q, cp_q;
  logic signed [15:0]   sy1_q, cy1_q;
  logic signed [31:0]   rc_q, rs_q;
  logic signed [47:0]   px_q, pz_q;
  logic signed [31:0]   py_q;
  logic signed [17:0]   ox, oz;
  logic signed [16:0]   oy;
  logic signed [25:0]   sx, sy_sum, sz;
  logic signed [24:0]   ex_q, ey_q, ez_q;

  assign en         = !vo_q || out_ready_i;
  assign in_ready_o = en;

  oep_cordic #(.STAGES(STAGES)) u_cordic_yaw (
    .clk_i (clk_i),
    .en_i  (en),
    .z_i   (in_i.z_yaw),
    .sin_o (sy_raw),
    .cos_o (cy_raw)
  );

  oep_cordic #(.STAGES(STAGES)) u_cordic_pitch (
    .clk_i (clk_i),
    .en_i  (en),
    .z_i   (in_i.z_pitch),
    .sin_o (sp_raw),
    .cos_o (cp_raw)
  );

  // Q30 to Q1.15 with rounding and saturation
  function automatic logic signed [15:0] to_q15(input logic signed [XW-1:0] v,
                                                input logic neg);
    logic signed [XW:0]    w;
    logic signed [XW-15:0] r;
    w = neg ? -(XW+1)'(v) : (XW+1)'(v);
    r = (XW-14)'((w + (XW+1)'(1 << 14)) >>> 15);
    if (r > (XW-14)'(32767))       return 16'sh7fff;
    else if (r < -(XW-14)'(32768)) return 16'sh8000;
    else                           return 16'(r);
  endfunction

  // Final offsets, target add and saturation
  function automatic logic signed [24:0] sat_eye(input logic signed [25:0] v);
    if (v > 26'(EYE_MAX))      return 25'(EYE_MAX);
    else if (v < 26'(EYE_MIN)) return 25'(EYE_MIN);
    else                       return 25'(v);
  endfunction

  always_comb begin
    ox     = 18'((px_q + 48'sd536870912) >>> 30);
    oz     = 18'((pz_q + 48'sd536870912) >>> 30);
    oy     = 17'((py_q + 32'sd16384) >>> 15);
    sx     = 26'(target_x_i) + 26'(ox);
    sy_sum = 26'(target_y_i) + 26'(oy);
    sz     = 26'(target_z_i) + 26'(oz);
  end

  // Valid chain alongside the CORDIC stages, rounding, multiply and output stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STAGES; i++) v_q[i] <= 1'b0;
      vr_q  <= 1'b0;
      vm1_q <= 1'b0;
      vm2_q <= 1'b0;
      vo_q  <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid_i;
      for (int i = 1; i < STAGES; i++) v_q[i] <= v_q[i-1];
      vr_q  <= v_q[STAGES-1];
      vm1_q <= vr_q;
      vm2_q <= vm1_q;
      vo_q  <= vm2_q;
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      f_q[0] <= in_i.flip;
      for (int i = 1; i < STAGES; i++) f_q[i] <= f_q[i-1];
      sy_q  <= to_q15(sy_raw, f_q[STAGES-1]);
      cy_q  <= to_q15(cy_raw, f_q[STAGES-1]);
      sp_q  <= to_q15(sp_raw, 1'b0);
      cp_q  <= to_q15(cp_raw, 1'b0);
      rc_q  <= $signed({1'b0, radius_i}) * cp_q;
      rs_q  <= $signed({1'b0, radius_i}) * sp_q;
      sy1_q <= sy_q;
      cy1_q <= cy_q;
      px_q  <= rc_q * sy1_q;
      pz_q  <= rc_q * cy1_q;
      py_q  <= rs_q;
      ex_q  <= sat_eye(sx);
      ey_q  <= sat_eye(sy_sum);
      ez_q  <= sat_eye(sz);
    end
  end

  assign out_valid_o = vo_q;
  assign eye_x_o     = ex_q;
  assign eye_y_o     = ey_q;
  assign eye_z_o     = ez_q;

endmodule

`default_nettype wire
